[rtl/swmm_pkg.sv]
// Shared constants, word types and control types of the sliding-window max/min/sum unit.
package swmm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WIN_W    = 7;
	localparam int SUM_W    = 64;
	localparam int DEPTH    = 64;
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int CNT_W    = PTR_W + 1;
	localparam int NQ       = 2;

	// Queue index of the decreasing queue (maximum) and the increasing one (minimum).
	localparam int Q_MAX = 0;
	localparam int Q_MIN = 1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] window_max;
		logic signed [SAMPLE_W-1:0] window_min;
		logic signed [SUM_W-1:0]    running_sum;
		logic                       window_full;
		logic                       final_res;
	} out_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] val;
		logic [WIN_W-1:0]           pos;
	} qent_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXP,
		ST_PSH
	} swmm_state_t;

	typedef struct packed {
		logic load;
		logic exp;
		logic psh;
		logic commit;
	} swmm_cmd_t;

	typedef struct packed {
		logic hit;
		logic drop;
		logic stall;
	} swmm_sts_t;

endpackage

[rtl/swmm_ctrl.sv]
// Sequencer of the sliding-window unit: expire phase, push phase and commit.
module swmm_ctrl import swmm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  swmm_sts_t sts,
	output swmm_cmd_t cmd
);

	swmm_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_EXP;
			end
			ST_EXP: begin
				if (!sts.hit) state_nx = ST_PSH;
			end
			ST_PSH: begin
				if (!sts.drop && !sts.stall) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXP: begin
				cmd.exp = 1'b1;
			end
			ST_PSH: begin
				cmd.psh    = 1'b1;
				cmd.commit = !sts.drop && !sts.stall;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/swmm_dp.sv]
// Datapath of the sliding-window unit: two monotonic queues in memory, counters and the sum.
module swmm_dp import swmm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  swmm_cmd_t        cmd,
	output swmm_sts_t        sts,
	input  in_word_t         in_data,
	input  logic             cfg_valid,
	input  logic [WIN_W-1:0] cfg_data,
	input  logic             out_ready,
	output logic             out_valid,
	output out_word_t        out_data
);

	logic [WIN_W-1:0]           win_q;
	logic [WIN_W-1:0]           k;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic [WIN_W-1:0]           pos_q;
	logic [WIN_W-1:0]           samp_q;
	logic [WIN_W-1:0]           samp_nx;
	logic [SUM_W-1:0]           sum_q;
	logic [SUM_W-1:0]           sum_nx;
	logic                       full;
	logic                       res_needed;
	logic                       stall;
	logic                       out_valid_q;
	out_word_t                  out_data_q;

	logic [NQ-1:0]              hit;
	logic [NQ-1:0]              drop;
	logic [CNT_W-1:0]           cnt_q  [NQ];
	logic [PTR_W-1:0]           head_q [NQ];
	logic signed [SAMPLE_W-1:0] front  [NQ];

	// Zero acts as one and anything above the queue depth saturates.
	always_comb begin
		if (win_q == '0) begin
			k = WIN_W'(1);
		end else if (win_q > WIN_W'(DEPTH)) begin
			k = WIN_W'(DEPTH);
		end else begin
			k = win_q;
		end
	end

	assign samp_nx    = (samp_q == '1) ? samp_q : samp_q + WIN_W'(1);
	assign full       = samp_nx >= k;
	assign res_needed = full || last_q;
	assign stall      = res_needed && out_valid_q && !out_ready;
	assign sum_nx     = sum_q + {{(SUM_W-SAMPLE_W){front[Q_MAX][SAMPLE_W-1]}}, front[Q_MAX]}
	                          + {{(SUM_W-SAMPLE_W){front[Q_MIN][SAMPLE_W-1]}}, front[Q_MIN]};

	assign sts.hit   = |hit;
	assign sts.drop  = |drop;
	assign sts.stall = stall;

	for (genvar g = 0; g < NQ; g++) begin : g_q
		qent_t                      mem [DEPTH];
		qent_t                      rd_q;
		qent_t                      wr_ent;
		logic signed [SAMPLE_W-1:0] front_q;
		logic [PTR_W-1:0]           raddr;
		logic [PTR_W-1:0]           waddr;
		logic [PTR_W-1:0]           back;
		logic [PTR_W-1:0]           back_prev;
		logic [WIN_W-1:0]           age;
		logic                       we;

		assign back      = head_q[g] + cnt_q[g][PTR_W-1:0] - PTR_W'(1);
		assign back_prev = back - PTR_W'(1);
		assign waddr     = head_q[g] + cnt_q[g][PTR_W-1:0];
		assign we        = cmd.commit && (cnt_q[g] < CNT_W'(DEPTH));
		assign wr_ent    = '{val: sample_q, pos: pos_q};

		// Ages never exceed the depth, so the position difference modulo 2^WIN_W is exact.
		assign age    = pos_q - rd_q.pos;
		assign hit[g] = (cnt_q[g] != '0) && (age >= k);

		if (g == Q_MAX) begin : g_cmp
			assign drop[g] = (cnt_q[g] != '0) && ($signed(sample_q) >= $signed(rd_q.val));
		end else begin : g_cmp
			assign drop[g] = (cnt_q[g] != '0) && ($signed(sample_q) <= $signed(rd_q.val));
		end

		// An emptied queue has the new sample as its only entry.
		assign front[g] = (cnt_q[g] == '0) ? sample_q : front_q;

		// The read issued in each cycle fetches what the next check needs.
		always_comb begin
			if (cmd.exp) begin
				if (hit[g]) begin
					raddr = head_q[g] + PTR_W'(1);
				end else if (sts.hit) begin
					raddr = head_q[g];
				end else begin
					raddr = back;
				end
			end else if (cmd.psh) begin
				if (drop[g]) begin
					raddr = back_prev;
				end else if (cmd.commit) begin
					raddr = last_q ? '0 : head_q[g];
				end else begin
					raddr = back;
				end
			end else begin
				raddr = head_q[g];
			end
		end

		always_ff @(posedge clk) begin
			if (we) begin
				mem[waddr] <= wr_ent;
			end
			if (we && (waddr == raddr)) begin
				rd_q <= wr_ent;
			end else begin
				rd_q <= mem[raddr];
			end
			if (cmd.exp) begin
				front_q <= rd_q.val;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				head_q[g] <= '0;
				cnt_q[g]  <= '0;
			end else if (cmd.exp && hit[g]) begin
				head_q[g] <= head_q[g] + PTR_W'(1);
				cnt_q[g]  <= cnt_q[g] - CNT_W'(1);
			end else if (cmd.psh && drop[g]) begin
				cnt_q[g] <= cnt_q[g] - CNT_W'(1);
			end else if (cmd.commit) begin
				if (last_q) begin
					head_q[g] <= '0;
					cnt_q[g]  <= '0;
				end else if (we) begin
					cnt_q[g] <= cnt_q[g] + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_data.sample;
			last_q   <= in_data.last;
		end
		if (cmd.commit && res_needed) begin
			out_data_q.window_max  <= full ? front[Q_MAX] : '0;
			out_data_q.window_min  <= full ? front[Q_MIN] : '0;
			out_data_q.running_sum <= full ? sum_nx : '0;
			out_data_q.window_full <= full;
			out_data_q.final_res   <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WIN_W'(1);
			pos_q       <= '0;
			samp_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				win_q <= cfg_data;
			end
			if (cmd.commit) begin
				if (last_q) begin
					pos_q  <= '0;
					samp_q <= '0;
					sum_q  <= '0;
				end else begin
					pos_q  <= pos_q + WIN_W'(1);
					samp_q <= samp_nx;
					if (full) sum_q <= sum_nx;
				end
			end
			if (cmd.commit && res_needed) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[Q_MAX] <= CNT_W'(DEPTH)) && (cnt_q[Q_MIN] <= CNT_W'(DEPTH)))
		else $error("queue count beyond depth");

	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result word appeared without a commit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && res_needed |-> !(out_valid_q && !out_ready))
		else $error("pending result word overwritten");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && last_q |=> (cnt_q[Q_MAX] == '0) && (cnt_q[Q_MIN] == '0)
			&& (samp_q == '0) && (sum_q == '0))
		else $error("state not cleared after the final word");

endmodule

[rtl/sliding_window_max_min_sum_unit.sv]
// Sequence: after input accept, the word passes through the expire phase, which pops
// expired front entries, and the push phase, which pops back entries and then loads the
// result (both queues scan side by side, so the queue with more of them sets the length);
// the push phase also waits while a pending result is held at the output. A new word is
// taken only in the idle phase; the scans issue one read per queue memory per cycle.
// Reset: arst_n clears the queues, counters, sum and output valid at once; the
// window size register returns to 1. Queue memories are not cleared.
module sliding_window_max_min_sum_unit import swmm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [WIN_W-1:0] cfg_data
);

	// The controller steps one sample through three phases. In the idle phase it
	// takes the word; the expire phase drops front entries that left the window;
	// the push phase drops back entries the new sample dominates, then appends the
	// sample (a last word empties the queues instead) and, if a result is due, loads
	// the output register. It holds a finished result while the next word is taken and worked on.
	swmm_cmd_t cmd;
	swmm_sts_t sts;

	// The window size register is written whenever cfg_valid is high, so the port never stalls.
	assign cfg_ready = 1'b1;

	swmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath keeps both queues, the position and sample counters, and the
	// 64-bit wrapping sum of window maximum plus minimum.
	swmm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
